[hw/rtl/single_cycle_risc_subset_core_defines.svh]
// Assertion helpers used by the checker file.
`ifndef SINGLE_CYCLE_RISC_SUBSET_CORE_DEFINES_SVH
`define SINGLE_CYCLE_RISC_SUBSET_CORE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define SCRC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define SCRC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/scrc_pkg.sv]
package scrc_pkg;

    localparam int unsigned DATA_WORDS_DEF = 1024;

    // opcodes, bits 31:26
    localparam logic [5:0] OP_RTYPE = 6'b000000;
    localparam logic [5:0] OP_J     = 6'b000010;
    localparam logic [5:0] OP_BEQ   = 6'b000100;
    localparam logic [5:0] OP_ADDI  = 6'b001000;
    localparam logic [5:0] OP_ADDIU = 6'b001001;
    localparam logic [5:0] OP_LI    = 6'b001111;
    localparam logic [5:0] OP_LW    = 6'b100011;
    localparam logic [5:0] OP_SW    = 6'b101011;

    // function codes, bits 4:0
    localparam logic [4:0] FN_ADD  = 5'b10000;
    localparam logic [4:0] FN_SUB  = 5'b10010;
    localparam logic [4:0] FN_MULT = 5'b00010;
    localparam logic [4:0] FN_OR   = 5'b01101;
    localparam logic [4:0] FN_XOR  = 5'b00110;

    typedef struct packed {
        logic [31:0] next_pc;
        logic        reg_we;
        logic [4:0]  reg_idx;
        logic [31:0] alu_val;
        logic        is_lw;
        logic        mem_we;
        logic [31:0] mem_addr;
        logic [31:0] mem_val;
        logic        eq;
    } t_exec;

endpackage

[hw/rtl/scrc_exec.sv]
module scrc_exec (
    input  logic [31:0]    i_instr,
    input  logic [31:0]    i_a,
    input  logic [31:0]    i_b,
    input  logic [31:0]    i_pc,
    output scrc_pkg::t_exec o_res
);
    import scrc_pkg::*;

    logic [5:0]  op;
    logic [4:0]  rt;
    logic [4:0]  rd;
    logic [4:0]  fn;
    logic [31:0] imm;
    logic [31:0] sum;
    logic [31:0] prod;
    logic [31:0] rval;

    assign op   = i_instr[31:26];
    assign rt   = i_instr[20:16];
    assign rd   = i_instr[15:11];
    assign fn   = i_instr[4:0];
    assign imm  = {16'h0000, i_instr[15:0]};
    assign sum  = i_a + imm;
    assign prod = i_a * i_b;

    always_comb begin
        case (fn)
            FN_ADD:  rval = i_a + i_b;
            FN_SUB:  rval = i_a - i_b;
            FN_MULT: rval = prod;
            FN_OR:   rval = i_a | i_b;
            FN_XOR:  rval = i_a ^ i_b;
            default: rval = '0;
        endcase
    end

    always_comb begin
        o_res          = '0;
        o_res.next_pc  = i_pc + 32'd4;
        o_res.eq       = (i_a == i_b);
        case (op)
            OP_RTYPE: begin
                o_res.reg_we  = 1'b1;
                o_res.reg_idx = rd;
                o_res.alu_val = rval;
            end
            OP_ADDI, OP_ADDIU, OP_LI: begin
                o_res.reg_we  = 1'b1;
                o_res.reg_idx = rt;
                o_res.alu_val = sum;
            end
            OP_LW: begin
                o_res.reg_we   = 1'b1;
                o_res.reg_idx  = rt;
                o_res.is_lw    = 1'b1;
                o_res.mem_addr = sum;
            end
            OP_SW: begin
                o_res.mem_we   = 1'b1;
                o_res.mem_addr = sum;
                o_res.mem_val  = i_b;
            end
            OP_BEQ: begin
                // absolute target: immediate plus four
                if (i_a == i_b) begin
                    o_res.next_pc = imm + 32'd4;
                end
            end
            OP_J: begin
                o_res.next_pc = {6'b000000, i_instr[25:0]};
            end
            default: begin
            end
        endcase
    end

endmodule

[hw/rtl/scrc_dmem.sv]
module scrc_dmem #(
    parameter int unsigned DATA_WORDS = scrc_pkg::DATA_WORDS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_rd_en,
    input  logic                          i_wr_en,
    input  logic [$clog2(DATA_WORDS)-1:0] i_addr,
    input  logic [31:0]                   i_wdata,
    output logic [31:0]                   o_rdata,
    output logic                          o_busy
);
    import scrc_pkg::*;

    localparam int unsigned AW = $clog2(DATA_WORDS);

    logic [31:0]   r_mem [DATA_WORDS];
    logic [31:0]   r_rdata;
    logic [AW-1:0] r_clr_idx;
    logic          r_busy;

    // zero sweep after reset, one word per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b1;
            r_clr_idx <= '0;
        end else if (r_busy) begin
            r_clr_idx <= r_clr_idx + 1'b1;
            if (r_clr_idx == AW'(DATA_WORDS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_mem[r_clr_idx] <= '0;
        end else if (i_wr_en) begin
            r_mem[i_addr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;
    assign o_busy  = r_busy;

endmodule

[hw/rtl/single_cycle_risc_subset_core.sv]
// Executes one instruction word per item and reports the next PC plus the register and
// memory writes the instruction made. An item is accepted every cycle in which o_stall is
// low; its result passes through the operand read, execute/memory access and output
// registers in that order. Register-file results are forwarded, so no instruction mix
// slows the rate. After reset the data memory is zeroed one word per cycle, and o_stall
// stays high until the sweep is done. DATA_WORDS must be a power of two; the data memory
// is indexed by the low address bits.
module single_cycle_risc_subset_core #(
    parameter int unsigned DATA_WORDS = scrc_pkg::DATA_WORDS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_instr_word,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_next_pc,
    output logic        o_reg_written,
    output logic [4:0]  o_reg_index,
    output logic [31:0] o_reg_value,
    output logic        o_mem_written,
    output logic [31:0] o_mem_address,
    output logic [31:0] o_mem_value,
    output logic        o_equal_flag
);
    import scrc_pkg::*;

    localparam int unsigned AW = $clog2(DATA_WORDS);

    // handshake / stage moves
    logic accept, out_free, s2_free, s2_move, s1_free, s1_move, dm_busy;

    // operand stage
    logic        r_s1_v;
    logic [31:0] r_s1_instr;
    logic [31:0] r_rs_q;
    logic [31:0] r_rt_q;
    logic        r_byp_v;
    logic [4:0]  r_byp_idx;
    logic [31:0] r_byp_val;
    logic [31:0] r_pc;

    // register file
    logic [31:0] r_rf [32];
    logic [31:0] r_rf_vld;

    // execute stage
    logic        r_s2_v;
    t_exec       r_s2;
    logic [31:0] s2_val;
    logic [31:0] dm_rdata;

    // output register
    logic        r_out_v;
    logic [31:0] r_next_pc;
    logic        r_reg_written;
    logic [4:0]  r_reg_index;
    logic [31:0] r_reg_value;
    logic        r_mem_written;
    logic [31:0] r_mem_address;
    logic [31:0] r_mem_value;
    logic        r_equal_flag;

    logic [4:0]  s1_rs, s1_rt;
    logic [31:0] op_a, op_b;
    t_exec       ex;

    assign out_free = !r_out_v || !i_stall;
    assign s2_move  = r_s2_v && out_free;
    assign s2_free  = !r_s2_v || out_free;
    assign s1_move  = r_s1_v && s2_free;
    assign s1_free  = !r_s1_v || s2_free;
    assign o_stall  = dm_busy || !s1_free;
    assign accept   = i_valid && !o_stall;

    assign s2_val = r_s2.is_lw ? dm_rdata : r_s2.alu_val;

    // operand forwarding: the item in execute is youngest, then the write that
    // landed on the same edge the register file was read
    assign s1_rs = r_s1_instr[25:21];
    assign s1_rt = r_s1_instr[20:16];

    always_comb begin
        if (r_s2_v && r_s2.reg_we && r_s2.reg_idx == s1_rs) begin
            op_a = s2_val;
        end else if (r_byp_v && r_byp_idx == s1_rs) begin
            op_a = r_byp_val;
        end else begin
            op_a = r_rs_q;
        end
        if (r_s2_v && r_s2.reg_we && r_s2.reg_idx == s1_rt) begin
            op_b = s2_val;
        end else if (r_byp_v && r_byp_idx == s1_rt) begin
            op_b = r_byp_val;
        end else begin
            op_b = r_rt_q;
        end
    end

    scrc_exec u_exec (
        .i_instr (r_s1_instr),
        .i_a     (op_a),
        .i_b     (op_b),
        .i_pc    (r_pc),
        .o_res   (ex)
    );

    scrc_dmem #(
        .DATA_WORDS (DATA_WORDS)
    ) u_dmem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd_en (s1_move),
        .i_wr_en (s1_move && ex.mem_we),
        .i_addr  (ex.mem_addr[AW-1:0]),
        .i_wdata (ex.mem_val),
        .o_rdata (dm_rdata),
        .o_busy  (dm_busy)
    );

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v   <= 1'b0;
            r_s2_v   <= 1'b0;
            r_out_v  <= 1'b0;
            r_pc     <= '0;
            r_rf_vld <= '0;
            r_byp_v  <= 1'b0;
        end else begin
            if (s1_free) begin
                r_s1_v <= accept;
            end
            if (s2_free) begin
                r_s2_v <= r_s1_v;
            end
            if (out_free) begin
                r_out_v <= r_s2_v;
            end
            if (s1_move) begin
                r_pc <= ex.next_pc;
            end
            if (s2_move && r_s2.reg_we) begin
                r_rf_vld[r_s2.reg_idx] <= 1'b1;
            end
            if (accept) begin
                r_byp_v <= s2_move && r_s2.reg_we;
            end
        end
    end

    // register file write, committed as the item leaves execute
    always_ff @(posedge i_clk) begin
        if (s2_move && r_s2.reg_we) begin
            r_rf[r_s2.reg_idx] <= s2_val;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_instr <= i_instr_word;
            r_rs_q     <= r_rf_vld[i_instr_word[25:21]] ? r_rf[i_instr_word[25:21]] : '0;
            r_rt_q     <= r_rf_vld[i_instr_word[20:16]] ? r_rf[i_instr_word[20:16]] : '0;
            r_byp_idx  <= r_s2.reg_idx;
            r_byp_val  <= s2_val;
        end
        if (s1_move) begin
            r_s2 <= ex;
        end
        if (s2_move) begin
            r_next_pc     <= r_s2.next_pc;
            r_reg_written <= r_s2.reg_we;
            r_reg_index   <= r_s2.reg_idx;
            r_reg_value   <= r_s2.reg_we ? s2_val : '0;
            r_mem_written <= r_s2.mem_we;
            r_mem_address <= r_s2.mem_addr;
            r_mem_value   <= r_s2.mem_val;
            r_equal_flag  <= r_s2.eq;
        end
    end

    assign o_valid       = r_out_v;
    assign o_next_pc     = r_next_pc;
    assign o_reg_written = r_reg_written;
    assign o_reg_index   = r_reg_index;
    assign o_reg_value   = r_reg_value;
    assign o_mem_written = r_mem_written;
    assign o_mem_address = r_mem_address;
    assign o_mem_value   = r_mem_value;
    assign o_equal_flag  = r_equal_flag;

endmodule

[hw/rtl/scrc_checker.sv]
`include "single_cycle_risc_subset_core_defines.svh"

module scrc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_next_pc,
    input logic        o_reg_written,
    input logic [4:0]  o_reg_index,
    input logic [31:0] o_reg_value,
    input logic        o_mem_written,
    input logic [31:0] o_mem_value
);

    // a stalled result keeps its PC
    `SCRC_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_next_pc), "stalled result changed")

    // no register write means index and value read zero
    `SCRC_ASSERT_NOW(a_no_reg_zero, o_valid && !o_reg_written, o_reg_index == 5'd0 && o_reg_value == 32'd0, "idle register fields not zero")

    // a store never writes a register
    `SCRC_ASSERT_NOW(a_store_excl, o_valid && o_mem_written, !o_reg_written, "store also wrote a register")

    // store data only shows with a store
    `SCRC_ASSERT_NOW(a_mem_val_zero, o_valid && !o_mem_written, o_mem_value == 32'd0, "store data without a store")

endmodule

bind single_cycle_risc_subset_core scrc_checker u_scrc_checker (.*);
